>>> src/jads_pkg.sv
// ---------------------------------------------------------------------------
// jads_pkg: shared types and constants for the joystick axis conditioner
// Beat layouts, register indexes and fixed widths of the axis datapath.
// ---------------------------------------------------------------------------
package jads_pkg;

  // Converter sample width and derived full-scale value
  localparam int unsigned SAMPLE_BITS = 12;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

  // Calibration accumulator width, also the divider dividend width
  localparam int unsigned SUM_BITS = 24;

  // Percent scale factor and its width
  localparam int unsigned PCT_BITS = 7;
  localparam logic [PCT_BITS-1:0] PERCENT = 7'd100;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] REG_INVERT_AXIS     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_PRESET   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEADZONE_PRESET = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PARAM_SOURCE    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CALIB_SAMPLES   = 3'd4;

  // Reset values
  localparam logic [SAMPLE_BITS-1:0] CENTER_RST        = 12'd2048;
  localparam logic [SAMPLE_BITS-1:0] CALIB_SAMPLES_RST = 12'd1300;

  // Mode codes of an input beat
  localparam logic MODE_CONVERT   = 1'b0;
  localparam logic MODE_CALIBRATE = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [SAMPLE_BITS-1:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [7:0]      position;
    logic                   calibration_done;
    logic [SAMPLE_BITS-1:0] center_out;
    logic [SAMPLE_BITS-1:0] deadzone_out;
  } out_t;

endpackage

>>> src/joystick_axis_deadzone_scaler.sv
// ---------------------------------------------------------------------------
// joystick_axis_deadzone_scaler: one-axis joystick conditioner
// Inverts, applies a dead zone and scales a 12-bit sample to signed percent,
// or runs a calibration that derives center and dead zone from a sample run.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_ready  | in_t  {mode, sample}
//  out     | output    | out_valid / out_ready| out_t {position, done, ...}
//  cfg     | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
//  An item that ends without a division (a dead-zone convert, a seeding or a
//  summing sample) passes through accept, setup and emit. A calibration mean
//  adds divide and finish steps, and a percent scale also a multiply step: the
//  shared restoring divider retires one quotient bit per cycle.
//  in_ready is high only while the sequencer is idle; a finished beat waits in
//  the output register, and the next item is taken while it waits.
//  Reset is synchronous and active high; there is no clearing pass.
//
module joystick_axis_deadzone_scaler
  import jads_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_t                      in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_t                     out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SUM_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state;

  // Configuration registers
  logic                   invert_axis;
  logic [SAMPLE_BITS-1:0] center_preset;
  logic [SAMPLE_BITS-1:0] deadzone_preset;
  logic                   param_source;
  logic [SAMPLE_BITS-1:0] calib_samples;

  // Calibration state
  logic [SAMPLE_BITS-1:0] cal_center;
  logic [SAMPLE_BITS-1:0] cal_deadzone;
  logic                   run_active;
  logic [SAMPLE_BITS-1:0] run_count;
  logic [SUM_BITS-1:0]    run_sum;
  logic [SAMPLE_BITS-1:0] run_min;
  logic [SAMPLE_BITS-1:0] run_max;

  // Item working registers
  logic                   mode;
  logic [SAMPLE_BITS-1:0] samp;
  logic [SAMPLE_BITS-1:0] mag;
  logic                   neg;
  logic                   cal_run;
  logic signed [7:0]      position;
  logic                   done;

  // Shared divider registers
  logic [SAMPLE_BITS-1:0] divisor;
  logic [SAMPLE_BITS-1:0] rem;
  logic [SUM_BITS-1:0]    quo;
  logic [STEP_BITS-1:0]   step;

  // Convert path decisions
  logic [SAMPLE_BITS-1:0] center_sel;
  logic [SAMPLE_BITS-1:0] dead_sel;
  logic                   above;
  logic [SAMPLE_BITS-1:0] mag_c;
  logic [SAMPLE_BITS-1:0] div_c;
  logic                   zero_c;

  always_comb begin
    center_sel = param_source ? cal_center : center_preset;
    dead_sel   = param_source ? cal_deadzone : deadzone_preset;
    above      = samp > center_sel;
    mag_c      = above ? samp - center_sel : center_sel - samp;
    div_c      = above ? FULL_SCALE - center_sel : center_sel;
    zero_c     = (mag_c <= dead_sel) || (!above && center_sel == '0);
  end

  // Calibration accumulate path
  logic [SAMPLE_BITS-1:0] n_c;
  logic [SUM_BITS-1:0]    sum_next;
  logic [SAMPLE_BITS-1:0] count_next;
  logic [SAMPLE_BITS-1:0] min_next;
  logic [SAMPLE_BITS-1:0] max_next;

  always_comb begin
    n_c        = (calib_samples == '0) ? SAMPLE_BITS'(1) : calib_samples;
    sum_next   = run_sum + SUM_BITS'(samp);
    count_next = run_count + SAMPLE_BITS'(1);
    min_next   = (samp < run_min) ? samp : run_min;
    max_next   = (samp > run_max) ? samp : run_max;
  end

  // One restoring divider step: shift in a dividend bit, trial subtract
  logic [SAMPLE_BITS:0]   rem_sh;
  logic                   ge;
  logic [SAMPLE_BITS-1:0] rem_next;
  logic [SUM_BITS-1:0]    quo_next;

  always_comb begin
    rem_sh   = {rem, quo[SUM_BITS-1]};
    ge       = rem_sh >= {1'b0, divisor};
    rem_next = ge ? SAMPLE_BITS'(rem_sh - {1'b0, divisor}) : SAMPLE_BITS'(rem_sh);
    quo_next = {quo[SUM_BITS-2:0], ge};
  end

  // Dead zone from the run extremes around the new center
  logic [SAMPLE_BITS-1:0] c_new;
  logic [SAMPLE_BITS-1:0] dev_max;
  logic [SAMPLE_BITS-1:0] dev_min;
  logic [SAMPLE_BITS-1:0] dz_c;

  always_comb begin
    c_new   = quo[SAMPLE_BITS-1:0];
    dev_max = (run_max > c_new) ? run_max - c_new : c_new - run_max;
    dev_min = (c_new > run_min) ? c_new - run_min : run_min - c_new;
    dz_c    = (dev_max > dev_min) ? dev_max : dev_min;
  end

  // Percent product fed into the divider
  logic [SAMPLE_BITS+PCT_BITS-1:0] prod;

  assign prod = (SAMPLE_BITS+PCT_BITS)'(mag) * (SAMPLE_BITS+PCT_BITS)'(PERCENT);

  assign in_ready = (state == S_IDLE);

  // Sequencer, configuration and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      invert_axis     <= 1'b1;
      center_preset   <= CENTER_RST;
      deadzone_preset <= '0;
      param_source    <= 1'b0;
      calib_samples   <= CALIB_SAMPLES_RST;
      cal_center      <= CENTER_RST;
      cal_deadzone    <= '0;
      run_active      <= 1'b0;
      run_count       <= '0;
      run_sum         <= '0;
      run_min         <= '0;
      run_max         <= '0;
      cal_run         <= 1'b0;
    end else begin
      // Take configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INVERT_AXIS:     invert_axis     <= cfg_data[0];
          REG_CENTER_PRESET:   center_preset   <= cfg_data[SAMPLE_BITS-1:0];
          REG_DEADZONE_PRESET: deadzone_preset <= cfg_data[SAMPLE_BITS-1:0];
          REG_PARAM_SOURCE:    param_source    <= cfg_data[0];
          REG_CALIB_SAMPLES:   calib_samples   <= cfg_data[SAMPLE_BITS-1:0];
          default: ;
        endcase
      end

      // Raise the output beat when loaded, drop it once taken
      if (state == S_EMIT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode  <= in_data.mode;
            samp  <= invert_axis ? FULL_SCALE - in_data.sample : in_data.sample;
            state <= S_SETUP;
          end
        end

        S_SETUP: begin
          position <= '0;
          done     <= 1'b0;
          if (mode == MODE_CONVERT) begin
            run_active <= 1'b0;
            mag        <= mag_c;
            divisor    <= div_c;
            neg        <= !above;
            state      <= zero_c ? S_EMIT : S_MUL;
          end else if (!run_active) begin
            // Seed a new run
            run_active <= 1'b1;
            run_count  <= '0;
            run_sum    <= '0;
            run_min    <= samp;
            run_max    <= samp;
            state      <= S_EMIT;
          end else begin
            run_sum   <= sum_next;
            run_count <= count_next;
            run_min   <= min_next;
            run_max   <= max_next;
            if (count_next >= n_c) begin
              quo     <= sum_next;
              divisor <= n_c;
              rem     <= '0;
              step    <= '0;
              cal_run <= 1'b1;
              state   <= S_DIV;
            end else begin
              state <= S_EMIT;
            end
          end
        end

        S_MUL: begin
          quo     <= SUM_BITS'(prod);
          rem     <= '0;
          step    <= '0;
          cal_run <= 1'b0;
          state   <= S_DIV;
        end

        S_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step + STEP_BITS'(1);
          if (step == LAST_STEP) begin
            state <= S_FIN;
          end
        end

        S_FIN: begin
          if (cal_run) begin
            cal_center   <= c_new;
            cal_deadzone <= dz_c;
            run_active   <= 1'b0;
            done         <= 1'b1;
            position     <= '0;
          end else begin
            position <= neg ? 8'sd0 - $signed(quo[7:0]) : $signed(quo[7:0]);
            done     <= 1'b0;
          end
          state <= S_EMIT;
        end

        S_EMIT: begin
          // Hold until the output register is free
          if (!out_valid || out_ready) begin
            out_data.position         <= position;
            out_data.calibration_done <= done;
            out_data.center_out       <= cal_center;
            out_data.deadzone_out     <= cal_deadzone;
            state                     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider remainder never reaches the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < divisor))
    else $error("divider remainder out of range");

  // Position stays within one hundred percent
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.position <= 8'sd100 && out_data.position >= -8'sd100))
    else $error("position outside percent range");

  // A completed calibration beat carries no deflection
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.calibration_done) |-> (out_data.position == 8'sd0))
    else $error("calibration beat with nonzero position");

  // Finishing a calibration division closes the run
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && cal_run) |=> (!run_active && done))
    else $error("calibration run not closed");

  // An accepted item keeps the input closed on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened while item in flight");

endmodule
